[sv/mbq_pkg.sv]
package mbq_pkg;

  // Field widths of the words on both channels.
  localparam int SAMPLE_W = 24;
  localparam int CH_W     = 3;

  // Configuration port.
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 32;
  localparam int COEF_W   = 32;
  localparam int ACT_W    = 4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_B0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 3'd7;

  // Reset values of the registers.
  localparam logic [COEF_W-1:0] COEF_B0_RST = 32'h1000_0000;
  localparam logic [ACT_W-1:0]  ACTIVE_RST  = 4'd1;

  // Channel state storage.
  localparam int MAX_CHANNELS = 8;
  localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_EXT_W = (CH_IDX_W > CH_W) ? CH_IDX_W : CH_W;
  localparam int DELAY_W  = 48;

  // Serial multiplier: the sample operand is consumed in 4-bit digits.
  localparam int DIG_W    = 4;
  localparam int DIGITS   = SAMPLE_W / DIG_W;
  localparam int DCNT_W   = $clog2(DIGITS);
  localparam int PP_W     = COEF_W + DIG_W + 1;
  localparam int ACC_W    = COEF_W + SAMPLE_W;
  localparam int PROD_SH  = 11;
  localparam int PROD_W   = ACC_W - PROD_SH;
  localparam int YACC_W   = DELAY_W + 1;
  localparam int Y_SH     = 17;
  localparam int Z_W      = DELAY_W + 2;

endpackage

[sv/mbq_stream_if.sv]
// Input channel: one sample word with its channel index.
interface mbq_in_if
  import mbq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic        [CH_W-1:0]     channel;

  modport source (output valid, output sample_in, output channel, input ready);
  modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

// Result channel: one filtered or passed-through sample word.
interface mbq_out_if
  import mbq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

[sv/multichannel_biquad_tdf2_core.sv]
// Multichannel biquad in transposed direct form II with Q4.28 coefficients and
// 48-bit delay terms per channel. A word is taken only while the sequencer is
// idle, so a word is finished before the next is taken: the five coefficient
// products share one digit-serial multiplier that takes the 24-bit operand four
// bits a cycle, and each product is then rounded and accumulated; the output
// saturation and the delay write-back follow, then the hand-off to the output
// register and the return to idle. A word that passes through (block disabled,
// neutral, or channel not active) leaves the delay state untouched.
// The result sits in an output register, so a new word is taken while the
// previous result still waits on the output side.
module multichannel_biquad_tdf2_core
  import mbq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  mbq_in_if.sink               in_ch,
  mbq_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_YSAT = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // Product being formed.
  localparam logic [2:0] K_B0 = 3'd0;
  localparam logic [2:0] K_B1 = 3'd1;
  localparam logic [2:0] K_B2 = 3'd2;
  localparam logic [2:0] K_A1 = 3'd3;
  localparam logic [2:0] K_A2 = 3'd4;

  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIGITS - 1);

  localparam logic signed [Z_W-1:0] DLY_MAX = Z_W'({1'b0, {(DELAY_W-1){1'b1}}});
  localparam logic signed [Z_W-1:0] DLY_MIN = -DLY_MAX - Z_W'(1);
  localparam int YSH_W = YACC_W + 1 - Y_SH;
  localparam logic signed [YSH_W-1:0] OUT_MAX = YSH_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
  localparam logic signed [YSH_W-1:0] OUT_MIN = -OUT_MAX - YSH_W'(1);

  // Configuration registers.
  logic signed [COEF_W-1:0] coef_r [5];
  logic                     enabled_r;
  logic                     neutral_r;
  logic [ACT_W-1:0]         active_r;

  // Control state.
  logic [2:0]        state_r;
  logic [2:0]        k_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              out_valid_r;
  logic              bypass_r;

  // Payload.
  logic signed [SAMPLE_W-1:0] x_r;
  logic [CH_IDX_W-1:0]        idx_r;
  logic [SAMPLE_W-1:0]        opnd_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [YACC_W-1:0]   yacc_r;
  logic signed [Z_W-1:0]      z1_r;
  logic signed [Z_W-1:0]      z2_r;
  logic signed [SAMPLE_W-1:0] res_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  // Per-channel delay terms.
  logic signed [DELAY_W-1:0] dly_one_r [MAX_CHANNELS];
  logic signed [DELAY_W-1:0] dly_two_r [MAX_CHANNELS];

  logic                       in_fire;
  logic                       filt;
  logic [CH_EXT_W-1:0]        ch_ext;
  logic signed [COEF_W-1:0]   coef_sel;
  logic signed [DIG_W:0]      sdig;
  logic signed [PP_W-1:0]     pp;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [ACC_W:0]      rnd_sum;
  logic signed [YACC_W:0]     ysum;
  logic signed [YSH_W-1:0]    yshift;
  logic signed [SAMPLE_W-1:0] y_nxt;
  logic signed [DELAY_W-1:0]  z1_sat;
  logic signed [DELAY_W-1:0]  z2_sat;
  logic                       out_load;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_fire           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_load          = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // A word is filtered only when the block is on, not neutral and the channel is active.
  assign filt = enabled_r && !neutral_r && ({1'b0, in_ch.channel} < active_r) &&
                (int'(in_ch.channel) < MAX_CHANNELS);
  assign ch_ext = CH_EXT_W'(in_ch.channel);

  // Coefficient for the current product.
  always_comb begin
    case (k_r)
      K_B0:    coef_sel = coef_r[0];
      K_B1:    coef_sel = coef_r[1];
      K_B2:    coef_sel = coef_r[2];
      K_A1:    coef_sel = coef_r[3];
      K_A2:    coef_sel = coef_r[4];
      default: coef_sel = '0;
    endcase
  end

  // Digit-serial multiply, most significant digit first; only the top digit is signed.
  assign sdig = (dcnt_r == '0) ? {opnd_r[SAMPLE_W-1], opnd_r[SAMPLE_W-1 -: DIG_W]}
                               : {1'b0, opnd_r[SAMPLE_W-1 -: DIG_W]};
  assign pp = coef_sel * sdig;
  assign acc_nxt = (dcnt_r == '0) ? ACC_W'(pp) : ((acc_r <<< DIG_W) + ACC_W'(pp));

  // Round half up to Q5.40, the fraction scale of the Q8.40 delay terms.
  assign rnd_sum = {acc_r[ACC_W-1], acc_r} + (ACC_W+1)'(1 << (PROD_SH - 1));

  // Output rounding and saturation of y.
  assign ysum   = {yacc_r[YACC_W-1], yacc_r} + (YACC_W+1)'(1 << (Y_SH - 1));
  assign yshift = ysum[YACC_W:Y_SH];
  always_comb begin
    if (yshift > OUT_MAX) begin
      y_nxt = OUT_MAX[SAMPLE_W-1:0];
    end else if (yshift < OUT_MIN) begin
      y_nxt = OUT_MIN[SAMPLE_W-1:0];
    end else begin
      y_nxt = yshift[SAMPLE_W-1:0];
    end
  end

  // Saturation of the new delay terms.
  always_comb begin
    if (z1_r > DLY_MAX) begin
      z1_sat = DLY_MAX[DELAY_W-1:0];
    end else if (z1_r < DLY_MIN) begin
      z1_sat = DLY_MIN[DELAY_W-1:0];
    end else begin
      z1_sat = z1_r[DELAY_W-1:0];
    end
    if (z2_r > DLY_MAX) begin
      z2_sat = DLY_MAX[DELAY_W-1:0];
    end else if (z2_r < DLY_MIN) begin
      z2_sat = DLY_MIN[DELAY_W-1:0];
    end else begin
      z2_sat = z2_r[DELAY_W-1:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= COEF_B0_RST;
      coef_r[1] <= '0;
      coef_r[2] <= '0;
      coef_r[3] <= '0;
      coef_r[4] <= '0;
      enabled_r <= 1'b0;
      neutral_r <= 1'b1;
      active_r  <= ACTIVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:      coef_r[0] <= cfg_wdata[COEF_W-1:0];
        REG_B1:      coef_r[1] <= cfg_wdata[COEF_W-1:0];
        REG_B2:      coef_r[2] <= cfg_wdata[COEF_W-1:0];
        REG_A1:      coef_r[3] <= cfg_wdata[COEF_W-1:0];
        REG_A2:      coef_r[4] <= cfg_wdata[COEF_W-1:0];
        REG_ENABLED: enabled_r <= cfg_wdata[0];
        REG_NEUTRAL: neutral_r <= cfg_wdata[0];
        REG_ACTIVE:  active_r  <= cfg_wdata[ACT_W-1:0];
        default:     ;
      endcase
    end
  end

  // Sequencer and output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= K_B0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
      bypass_r    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            bypass_r <= !filt;
            k_r      <= K_B0;
            dcnt_r   <= '0;
            state_r  <= filt ? ST_MUL : ST_DONE;
          end
        end
        ST_MUL: begin
          if (dcnt_r == DCNT_LAST) begin
            dcnt_r  <= '0;
            state_r <= ST_RND;
          end else begin
            dcnt_r <= dcnt_r + DCNT_W'(1);
          end
        end
        ST_RND: state_r <= ST_ACC;
        ST_ACC: begin
          if (k_r == K_B0) begin
            state_r <= ST_YSAT;
          end else if (k_r == K_A2) begin
            state_r <= ST_WB;
          end else begin
            k_r     <= k_r + 3'd1;
            state_r <= ST_MUL;
          end
        end
        ST_YSAT: begin
          k_r     <= K_B1;
          state_r <= ST_MUL;
        end
        ST_WB:   state_r <= ST_DONE;
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= res_r;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          x_r    <= in_ch.sample_in;
          res_r  <= in_ch.sample_in;
          opnd_r <= in_ch.sample_in;
          idx_r  <= ch_ext[CH_IDX_W-1:0];
        end
      end
      ST_MUL: begin
        acc_r  <= acc_nxt;
        opnd_r <= opnd_r << DIG_W;
      end
      ST_RND: prod_r <= rnd_sum[ACC_W-1:PROD_SH];
      ST_ACC: begin
        case (k_r)
          K_B0: yacc_r <= YACC_W'(prod_r) + YACC_W'(dly_one_r[idx_r]);
          K_B1: begin
            z1_r   <= Z_W'(prod_r) + Z_W'(dly_two_r[idx_r]);
            opnd_r <= x_r;
          end
          K_B2: begin
            z2_r   <= Z_W'(prod_r);
            opnd_r <= res_r;
          end
          K_A1: begin
            z1_r   <= z1_r - Z_W'(prod_r);
            opnd_r <= res_r;
          end
          K_A2:    z2_r <= z2_r - Z_W'(prod_r);
          default: ;
        endcase
      end
      ST_YSAT: begin
        res_r  <= y_nxt;
        opnd_r <= x_r;
      end
      default: ;
    endcase
  end

  // Delay state: cleared by reset, written once per filtered word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        dly_one_r[i] <= '0;
        dly_two_r[i] <= '0;
      end
    end else if (state_r == ST_WB) begin
      dly_one_r[idx_r] <= z1_sat;
      dly_two_r[idx_r] <= z2_sat;
    end
  end

  // A word that passes through leaves with its own value.
  a_bypass_value: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && bypass_r) |-> (res_r == x_r))
    else $error("passed-through word changed");

  // A filtered word starts the multiplier right after it is taken.
  a_filter_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && filt) |=> (state_r == ST_MUL && k_r == K_B0 && dcnt_r == '0))
    else $error("filtered word did not start the multiplier");

  // The last feedback product leads to the delay write-back.
  a_last_product: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC && k_r == K_A2) |=> (state_r == ST_WB))
    else $error("sequence skipped the delay write-back");

  // A new result is loaded only from the finishing state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside the finishing state");

endmodule

[tb/testbench.sv]
module testbench;
  import mbq_pkg::*;

  localparam int N_DIR_ROWS = 36;
  localparam int N_PHASES   = 12;
  localparam int PHASE_WORDS = 158;
  localparam longint Y_MAX = 64'sd8388607;
  localparam longint Y_MIN = -64'sd8388608;
  localparam longint D_MAX = (64'sd1 <<< (DELAY_W - 1)) - 64'sd1;
  localparam longint D_MIN = -(64'sd1 <<< (DELAY_W - 1));

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_W-1:0]           data;
    logic signed [SAMPLE_W-1:0] smp;
    logic [CH_W-1:0]            ch;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  mbq_in_if  in_ch();
  mbq_out_if out_ch();

  multichannel_biquad_tdf2_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the filter registers and per-channel delay terms.
  logic signed [COEF_W-1:0]  coef_val [0:4];
  logic                      filt_on;
  logic                      bypass_on;
  logic [ACT_W-1:0]          active_cnt;
  logic signed [DELAY_W-1:0] w1_acc [0:MAX_CHANNELS-1];
  logic signed [DELAY_W-1:0] w2_acc [0:MAX_CHANNELS-1];

  logic signed [SAMPLE_W-1:0] expected_samples [$];

  int err_cnt;
  int words_taken;
  int results_seen;
  int filtered_words;
  int passed_words;
  int reg_writes;
  int rx_mode;
  int burst_left;
  bit no_idle;
  bit drv_typed;
  logic signed [SAMPLE_W-1:0] drv_want;

  // Directed words: typed expectations only where the answer is obvious.
  stim_row_t dir_rows [0:N_DIR_ROWS-1] = '{
    // After reset the block is disabled, so words pass through.
    '{ROW_WORD, REG_B0, 32'd0, 24'h7FFFFF, 3'd0, 1'b1, 24'h7FFFFF},
    '{ROW_WORD, REG_B0, 32'd0, 24'h800000, 3'd7, 1'b1, 24'h800000},
    '{ROW_WORD, REG_B0, 32'd0, 24'sd0, 3'd3, 1'b1, 24'sd0},
    // Enabled but still neutral.
    '{ROW_CFG, REG_ENABLED, 32'd1, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, 24'sd12345, 3'd0, 1'b1, 24'sd12345},
    // Unity b0 with all other taps zero is an identity on channel zero.
    '{ROW_CFG, REG_NEUTRAL, 32'd0, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, 24'h7FFFFF, 3'd0, 1'b1, 24'h7FFFFF},
    '{ROW_WORD, REG_B0, 32'd0, 24'h800000, 3'd0, 1'b1, 24'h800000},
    '{ROW_WORD, REG_B0, 32'd0, 24'sd1000, 3'd1, 1'b1, 24'sd1000},
    // No active channel at all.
    '{ROW_CFG, REG_ACTIVE, 32'd0, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, -24'sd5, 3'd0, 1'b1, -24'sd5},
    // Active count beyond the channel count, extreme coefficients.
    '{ROW_CFG, REG_ACTIVE, 32'd15, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_B0, 32'h7FFFFFFF, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_B1, 32'h80000000, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_B2, 32'h7FFFFFFF, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_A1, 32'h80000000, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_A2, 32'h7FFFFFFF, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, 24'h7FFFFF, 3'd7, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, 24'h800000, 3'd7, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, 24'h7FFFFF, 3'd7, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, 24'sd0, 3'd6, 1'b0, 24'sd0},
    '{ROW_CFG, REG_B0, 32'h80000000, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_A1, 32'h7FFFFFFF, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_A2, 32'h80000000, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, 24'h800000, 3'd5, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, 24'h7FFFFF, 3'd5, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, 24'h800000, 3'd5, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, 24'sd1, 3'd0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_ACTIVE, 32'd8, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, -24'sd1, 3'd7, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, 24'h2AAAAA, 3'd2, 1'b0, 24'sd0},
    // Neutral again, then disabled with neutral cleared.
    '{ROW_CFG, REG_NEUTRAL, 32'd1, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, 24'sd4242, 3'd7, 1'b1, 24'sd4242},
    '{ROW_CFG, REG_ENABLED, 32'd0, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_NEUTRAL, 32'd0, 24'sd0, 3'd0, 1'b0, 24'sd0},
    '{ROW_WORD, REG_B0, 32'd0, -24'sd77, 3'd0, 1'b1, -24'sd77}
  };

  // Clock with a 12-unit period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Round half up while shifting right arithmetically.
  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Coefficient times sample, brought to the 40-fraction-bit delay format.
  function automatic longint coef_prod(input logic signed [COEF_W-1:0] c, input longint v);
    return rnd_shift(longint'(c) * v, PROD_SH);
  endfunction

  function automatic void clear_filter_state();
    coef_val[REG_B0] = COEF_B0_RST;
    coef_val[REG_B1] = '0;
    coef_val[REG_B2] = '0;
    coef_val[REG_A1] = '0;
    coef_val[REG_A2] = '0;
    filt_on    = 1'b0;
    bypass_on  = 1'b1;
    active_cnt = ACTIVE_RST;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      w1_acc[c] = '0;
      w2_acc[c] = '0;
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    reg_writes++;
    case (idx)
      REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: coef_val[idx] = d;
      REG_ENABLED: filt_on = d[0];
      REG_NEUTRAL: bypass_on = d[0];
      REG_ACTIVE: active_cnt = d[ACT_W-1:0];
      default: ;
    endcase
  endfunction

  // One biquad step in transposed direct form II; updates the channel state.
  function automatic logic signed [SAMPLE_W-1:0] biquad_predict(
      input logic signed [SAMPLE_W-1:0] x, input logic [CH_W-1:0] ch);
    longint xs, acc, y, n1, n2;
    if (!filt_on || bypass_on || ch >= active_cnt || int'(ch) >= MAX_CHANNELS) begin
      passed_words++;
      return x;
    end
    filtered_words++;
    xs  = x;
    acc = coef_prod(coef_val[REG_B0], xs) + longint'(w1_acc[ch]);
    y   = sat(rnd_shift(acc, Y_SH), Y_MIN, Y_MAX);
    n1  = coef_prod(coef_val[REG_B1], xs) - coef_prod(coef_val[REG_A1], y)
          + longint'(w2_acc[ch]);
    n2  = coef_prod(coef_val[REG_B2], xs) - coef_prod(coef_val[REG_A2], y);
    w1_acc[ch] = sat(n1, D_MIN, D_MAX);
    w2_acc[ch] = sat(n2, D_MIN, D_MAX);
    return y;
  endfunction

  // Monitor: track register writes, predict accepted words, check results.
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n) begin
      if (cfg_we) apply_reg(cfg_index, cfg_wdata);
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_samples.size() == 0) begin
          $error("sample_out: no word expected, actual %0d", out_ch.sample_out);
          err_cnt++;
        end else begin
          want = expected_samples.pop_front();
          if (out_ch.sample_out !== want) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want, out_ch.sample_out);
            err_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = biquad_predict(in_ch.sample_in, in_ch.channel);
        expected_samples.push_back(drv_typed ? drv_want : want);
        words_taken++;
      end
    end
  end

  // Result side: the ready pattern depends on the mode of the current phase.
  initial begin
    int tick;
    tick = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ((tick % 13) > 4);
      endcase
    end
  end

  // Present one word and hold it until it is taken.
  task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic [CH_W-1:0] ch,
                           input bit typed, input logic signed [SAMPLE_W-1:0] want);
    int mark;
    mark = words_taken;
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= smp;
    in_ch.channel   <= ch;
    drv_typed       <= typed;
    drv_want        <= want;
    do @(negedge clk); while (words_taken == mark);
  endtask

  // Sender pacing: bursts of words separated by idle gaps with junk on the bus, unless no_idle is set.
  task automatic pace();
    if (!no_idle && burst_left <= 0) begin
      in_ch.valid     <= 1'b0;
      in_ch.sample_in <= SAMPLE_W'($urandom);
      in_ch.channel   <= CH_W'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Run limit, far above the slowest legal run.
  initial begin
    #(12 * 800000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus.
  initial begin
    bit prev_word;
    logic [CFG_W-1:0] cv [0:4];
    logic signed [SAMPLE_W-1:0] smp;
    logic [CH_W-1:0] ch;
    int pick;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_ch.channel   = '0;
    drv_typed       = 1'b0;
    drv_want        = '0;
    rx_mode         = 1;
    no_idle         = 1'b0;
    burst_left      = 0;
    err_cnt         = 0;
    words_taken     = 0;
    results_seen    = 0;
    filtered_words  = 0;
    passed_words    = 0;
    reg_writes      = 0;
    clear_filter_state();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table.
    prev_word = 1'b1;
    for (int r = 0; r < N_DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        if (prev_word) wait_idle();
        reg_write(dir_rows[r].idx, dir_rows[r].data);
        prev_word = 1'b0;
      end else begin
        pace();
        send_word(dir_rows[r].smp, dir_rows[r].ch, dir_rows[r].typed, dir_rows[r].want);
        prev_word = 1'b1;
      end
    end

    // Random phases, each with its own filter setting and handshake style.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      no_idle = (ph % 4 == 1);
      rx_mode = no_idle ? 0 : $urandom_range(1, 2);
      pick = $urandom_range(0, 2);
      for (int k = 0; k < 5; k++) begin
        case (pick)
          // Roughly stable low-order shapes: small feed-forward, resonant feedback.
          0: cv[k] = (k < 3) ? $urandom_range(0, 32'h0100_0000)
                   : (k == 3) ? 32'h0 - $urandom_range(400000000, 530000000)
                   : $urandom_range(200000000, 260000000);
          1: cv[k] = $urandom;
          default: begin
            case ($urandom_range(0, 4))
              0: cv[k] = 32'h7FFF_FFFF;
              1: cv[k] = 32'h8000_0000;
              2: cv[k] = '0;
              3: cv[k] = COEF_B0_RST;
              default: cv[k] = $urandom;
            endcase
          end
        endcase
        if (ph == 0 || $urandom_range(0, 9) < 7)
          reg_write(CFG_IDX_W'(REG_B0 + k), cv[k]);
      end
      // Upper bits of the narrow registers carry junk; only the low bits count.
      reg_write(REG_ENABLED, ($urandom & ~32'h1) | 32'($urandom_range(0, 9) < 8));
      reg_write(REG_NEUTRAL, ($urandom & ~32'h1) | 32'($urandom_range(0, 9) < 2));
      if ($urandom_range(0, 4) == 0)
        reg_write(REG_ACTIVE, ($urandom & ~32'hF) | $urandom_range(0, 15));
      else
        reg_write(REG_ACTIVE, ($urandom & ~32'hF) | $urandom_range(1, MAX_CHANNELS));

      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (ph % 3 == 2 && i == PHASE_WORDS / 2) wait_idle();
        pace();
        case ($urandom_range(0, 9))
          0, 1: smp = $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
          2: smp = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
          default: smp = SAMPLE_W'($urandom);
        endcase
        // Most words go to active channels.
        if (active_cnt != 0 && $urandom_range(0, 9) < 8)
          ch = (active_cnt >= MAX_CHANNELS) ? CH_W'($urandom_range(0, MAX_CHANNELS - 1))
                                            : CH_W'($urandom_range(0, active_cnt - 1));
        else
          ch = CH_W'($urandom);
        send_word(smp, ch, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    $display("Run covered %0d words (%0d filtered, %0d passed through), %0d results checked,",
             words_taken, filtered_words, passed_words, results_seen);
    $display("%0d register writes over %0d random filter settings.", reg_writes, N_PHASES);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
